// ===== hw/rtl/i2ccrs_pkg.sv =====
// shared types and constants of the i2c command register slave
package i2ccrs_pkg;

    // bus event carried by each request
    typedef enum logic [1:0] {
        EV_ADDR_WRITE = 2'd0,
        EV_DATA       = 2'd1,
        EV_ADDR_READ  = 2'd2,
        EV_ABORT      = 2'd3
    } event_t;

    // armed master command
    typedef enum logic [1:0] {
        PEND_NONE    = 2'd0,
        PEND_READSET = 2'd1,
        PEND_WRITE   = 2'd2
    } pending_t;

    // progress through a command sequence
    typedef enum logic [1:0] {
        PHASE_IDLE = 2'd0,
        PHASE_CMD  = 2'd1,
        PHASE_ADDR = 2'd2
    } phase_t;

    // entry pointer update
    typedef enum logic [1:0] {
        PTR_KEEP       = 2'd0,
        PTR_LOAD       = 2'd1,
        PTR_LOAD_CLAMP = 2'd2,
        PTR_CLEAR      = 2'd3
    } ptr_op_t;

    localparam logic [7:0] BYTE_READSET = 8'hAA;
    localparam logic [7:0] BYTE_WRITE   = 8'h55;
    localparam logic [7:0] GC_SYNC      = 8'h43;  // 'C'
    localparam logic [7:0] GC_START     = 8'h53;  // 'S'
    localparam logic [7:0] GC_STOP      = 8'h50;  // 'P'

    localparam int MASK_W     = 64;
    localparam int MASK_IDX_W = 6;

    // controller to datapath
    typedef struct packed {
        logic    load;
        ptr_op_t ptr_op;
        logic    mem_we;
        logic    mem_rd;
        logic    rej;
        logic    syn;
        logic    sta;
        logic    sto;
    } dp_cmd_t;

    // datapath to controller: decode of the received byte
    typedef struct packed {
        logic is_readset;
        logic is_write;
        logic addr_bad;
        logic is_sync;
        logic is_start;
        logic is_stop;
    } dp_status_t;

endpackage

// ===== hw/rtl/i2ccrs_ctrl.sv =====
// controller: request handshake and transaction flags of the i2c slave
module i2ccrs_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_command,
    input  logic                   s_general_call,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  i2ccrs_pkg::dp_status_t status,
    output i2ccrs_pkg::dp_cmd_t    cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_RESP
    } state_t;

    state_t                state_reg, state_next;
    logic                  gc_pending_reg, gc_pending_next;
    logic                  addr_seen_reg, addr_seen_next;
    i2ccrs_pkg::phase_t    phase_reg, phase_next;
    i2ccrs_pkg::pending_t  pending_reg, pending_next;

    always_comb begin
        state_next      = state_reg;
        gc_pending_next = gc_pending_reg;
        addr_seen_next  = addr_seen_reg;
        phase_next      = phase_reg;
        pending_next    = pending_reg;
        cmd             = '0;
        cmd.ptr_op      = i2ccrs_pkg::PTR_KEEP;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_RESP;
                    unique case (i2ccrs_pkg::event_t'(s_command))
                        i2ccrs_pkg::EV_ADDR_WRITE: begin
                            if (s_general_call) begin
                                gc_pending_next = 1'b1;
                            end else begin
                                addr_seen_next = 1'b1;
                            end
                        end
                        i2ccrs_pkg::EV_DATA: begin
                            priority if (addr_seen_reg && !gc_pending_reg) begin
                                addr_seen_next = 1'b0;
                                phase_next     = i2ccrs_pkg::PHASE_CMD;
                                if (status.is_readset) begin
                                    pending_next = i2ccrs_pkg::PEND_READSET;
                                end else if (status.is_write) begin
                                    pending_next = i2ccrs_pkg::PEND_WRITE;
                                end
                            end else if (phase_reg == i2ccrs_pkg::PHASE_CMD &&
                                         pending_reg == i2ccrs_pkg::PEND_WRITE &&
                                         !gc_pending_reg) begin
                                if (status.addr_bad) begin
                                    gc_pending_next = 1'b0;
                                    addr_seen_next  = 1'b0;
                                    phase_next      = i2ccrs_pkg::PHASE_IDLE;
                                    pending_next    = i2ccrs_pkg::PEND_NONE;
                                    cmd.rej         = 1'b1;
                                end else begin
                                    cmd.ptr_op     = i2ccrs_pkg::PTR_LOAD;
                                    addr_seen_next = 1'b0;
                                    phase_next     = i2ccrs_pkg::PHASE_ADDR;
                                end
                            end else if (phase_reg == i2ccrs_pkg::PHASE_ADDR &&
                                         pending_reg == i2ccrs_pkg::PEND_WRITE &&
                                         !gc_pending_reg) begin
                                cmd.mem_we     = 1'b1;
                                cmd.ptr_op     = i2ccrs_pkg::PTR_CLEAR;
                                addr_seen_next = 1'b0;
                                phase_next     = i2ccrs_pkg::PHASE_IDLE;
                                pending_next   = i2ccrs_pkg::PEND_NONE;
                            end else if (phase_reg == i2ccrs_pkg::PHASE_CMD &&
                                         pending_reg == i2ccrs_pkg::PEND_READSET &&
                                         !gc_pending_reg) begin
                                cmd.ptr_op     = i2ccrs_pkg::PTR_LOAD_CLAMP;
                                addr_seen_next = 1'b0;
                                phase_next     = i2ccrs_pkg::PHASE_IDLE;
                                pending_next   = i2ccrs_pkg::PEND_NONE;
                            end else if (gc_pending_reg) begin
                                gc_pending_next = 1'b0;
                                addr_seen_next  = 1'b0;
                                phase_next      = i2ccrs_pkg::PHASE_IDLE;
                                cmd.syn         = status.is_sync;
                                cmd.sta         = status.is_start;
                                cmd.sto         = status.is_stop;
                            end else begin
                                gc_pending_next = 1'b0;
                                addr_seen_next  = 1'b0;
                                phase_next      = i2ccrs_pkg::PHASE_IDLE;
                                pending_next    = i2ccrs_pkg::PEND_NONE;
                                cmd.ptr_op      = i2ccrs_pkg::PTR_CLEAR;
                            end
                        end
                        i2ccrs_pkg::EV_ADDR_READ: begin
                            cmd.mem_rd      = 1'b1;
                            cmd.ptr_op      = i2ccrs_pkg::PTR_CLEAR;
                            gc_pending_next = 1'b0;
                            addr_seen_next  = 1'b0;
                            phase_next      = i2ccrs_pkg::PHASE_IDLE;
                        end
                        i2ccrs_pkg::EV_ABORT: begin
                            gc_pending_next = 1'b0;
                            addr_seen_next  = 1'b0;
                            phase_next      = i2ccrs_pkg::PHASE_IDLE;
                        end
                        default: begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_RESP: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            gc_pending_reg <= 1'b0;
            addr_seen_reg  <= 1'b0;
            phase_reg      <= i2ccrs_pkg::PHASE_IDLE;
            pending_reg    <= i2ccrs_pkg::PEND_NONE;
        end else begin
            state_reg      <= state_next;
            gc_pending_reg <= gc_pending_next;
            addr_seen_reg  <= addr_seen_next;
            phase_reg      <= phase_next;
            pending_reg    <= pending_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_RESP);

endmodule

// ===== hw/rtl/i2ccrs_dp.sv =====
// datapath: register file, entry pointer, write-protect mask and result register
module i2ccrs_dp #(
    parameter int REG_COUNT = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [i2ccrs_pkg::MASK_W-1:0]       cfg_mask,
    input  logic [7:0]                          rx_byte,
    input  i2ccrs_pkg::dp_cmd_t                 cmd,
    output i2ccrs_pkg::dp_status_t              status,
    output logic [7:0]                          tx_byte,
    output logic                                tx_valid,
    output logic                                entry_written,
    output logic                                write_rejected,
    output logic                                sync_pulse,
    output logic                                start_pulse,
    output logic                                stop_pulse
);

    localparam int         PTR_W   = $clog2(REG_COUNT);
    localparam logic [8:0] COUNT_9 = 9'(REG_COUNT);

    logic [i2ccrs_pkg::MASK_W-1:0] mask_reg;
    logic [PTR_W-1:0]              ptr_reg, ptr_next;
    logic [REG_COUNT-1:0]          valid_reg;
    logic [7:0]                    mem [REG_COUNT];
    logic                          rx_in_range;

    logic [7:0] tx_byte_reg;
    logic       tx_valid_reg, written_reg, rejected_reg;
    logic       sync_reg, start_reg, stop_reg;

    // byte decode
    assign rx_in_range       = ({1'b0, rx_byte} < COUNT_9);
    assign status.is_readset = (rx_byte == i2ccrs_pkg::BYTE_READSET);
    assign status.is_write   = (rx_byte == i2ccrs_pkg::BYTE_WRITE);
    assign status.addr_bad   = !rx_in_range ||
                               mask_reg[rx_byte[i2ccrs_pkg::MASK_IDX_W-1:0]];
    assign status.is_sync    = (rx_byte == i2ccrs_pkg::GC_SYNC);
    assign status.is_start   = (rx_byte == i2ccrs_pkg::GC_START);
    assign status.is_stop    = (rx_byte == i2ccrs_pkg::GC_STOP);

    always_comb begin
        ptr_next = ptr_reg;
        if (cmd.load) begin
            unique case (cmd.ptr_op)
                i2ccrs_pkg::PTR_KEEP:       ptr_next = ptr_reg;
                i2ccrs_pkg::PTR_LOAD:       ptr_next = rx_byte[PTR_W-1:0];
                i2ccrs_pkg::PTR_LOAD_CLAMP: ptr_next = rx_in_range ? rx_byte[PTR_W-1:0] : '0;
                i2ccrs_pkg::PTR_CLEAR:      ptr_next = '0;
                default:                    ptr_next = ptr_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg  <= '0;
            ptr_reg   <= '0;
            valid_reg <= '0;
        end else begin
            if (cfg_we) begin
                mask_reg <= cfg_mask;
            end
            ptr_reg <= ptr_next;
            if (cmd.load && cmd.mem_we) begin
                valid_reg[ptr_reg] <= 1'b1;
            end
        end
    end

    // register file storage and registered read
    always_ff @(posedge aclk) begin
        if (cmd.load && cmd.mem_we) begin
            mem[ptr_reg] <= rx_byte;
        end
        if (cmd.load) begin
            tx_byte_reg  <= (cmd.mem_rd && valid_reg[ptr_reg]) ? mem[ptr_reg] : 8'h00;
            tx_valid_reg <= cmd.mem_rd;
            written_reg  <= cmd.mem_we;
            rejected_reg <= cmd.rej;
            sync_reg     <= cmd.syn;
            start_reg    <= cmd.sta;
            stop_reg     <= cmd.sto;
        end
    end

    assign tx_byte        = tx_byte_reg;
    assign tx_valid       = tx_valid_reg;
    assign entry_written  = written_reg;
    assign write_rejected = rejected_reg;
    assign sync_pulse     = sync_reg;
    assign start_pulse    = start_reg;
    assign stop_pulse     = stop_reg;

endmodule

// ===== hw/rtl/i2c_command_register_slave.sv =====
// top level of the i2c command register slave: controller plus datapath
//
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    s_command, s_general_call, s_rx_byte
//  m_        out        m_valid / m_ready    m_tx_byte, m_tx_valid, m_entry_written,
//                                            m_write_rejected, m_sync/start/stop_pulse
//  cfg_      in         cfg_valid/cfg_ready  cfg_read_only_mask
//
// one request at a time: the block takes the request and does the single register-file
// access, then shows the result
// a stalled result holds the block in its response state; s_ready stays low until taken
// synchronous active-low reset clears flags, pointer, mask and the per-entry valid
// bits, so the register file reads as zero at once with no clearing pass
// cfg_ready is always high; the mask is taken whenever cfg_valid is high, so the user
// must write it only between requests; the block itself does not enforce this
module i2c_command_register_slave #(
    parameter int REG_COUNT = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_command,
    input  logic                            s_general_call,
    input  logic [7:0]                      s_rx_byte,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [7:0]                      m_tx_byte,
    output logic                            m_tx_valid,
    output logic                            m_entry_written,
    output logic                            m_write_rejected,
    output logic                            m_sync_pulse,
    output logic                            m_start_pulse,
    output logic                            m_stop_pulse,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [i2ccrs_pkg::MASK_W-1:0]   cfg_read_only_mask
);

    i2ccrs_pkg::dp_cmd_t    dp_cmd;
    i2ccrs_pkg::dp_status_t dp_status;

    // mask register always accepts
    assign cfg_ready = 1'b1;

    // transaction flags and handshake sequencing
    i2ccrs_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_general_call (s_general_call),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .status         (dp_status),
        .cmd            (dp_cmd)
    );

    // register file, pointer, mask and result register
    i2ccrs_dp #(
        .REG_COUNT (REG_COUNT)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_mask       (cfg_read_only_mask),
        .rx_byte        (s_rx_byte),
        .cmd            (dp_cmd),
        .status         (dp_status),
        .tx_byte        (m_tx_byte),
        .tx_valid       (m_tx_valid),
        .entry_written  (m_entry_written),
        .write_rejected (m_write_rejected),
        .sync_pulse     (m_sync_pulse),
        .start_pulse    (m_start_pulse),
        .stop_pulse     (m_stop_pulse)
    );

    // a request and a pending result never coexist
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request accepted while a result is pending");

    // every accepted request yields a result in the next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("accepted request produced no result");

    // transmit byte only carries data on a read match
    a_tx_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_tx_valid || (m_tx_byte == 8'h00)))
        else $error("tx byte nonzero without read match");

    // result indications exclude each other
    a_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot0({m_tx_valid, m_entry_written, m_write_rejected,
                              m_sync_pulse, m_start_pulse, m_stop_pulse}))
        else $error("more than one result indication set");

endmodule
